### hw/rtl/tabp_pkg.sv
// ----------------------------------------------------------------------------
// tabp_pkg
// Shared types, codes and type tables for the typed attribute blob parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tabp_pkg;

	localparam int COL_SLOTS = 256;
	localparam int COL_AW    = $clog2(COL_SLOTS);
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic OP_SCHEMA = 1'b0;
	localparam logic OP_BYTE   = 1'b1;

	localparam logic [1:0] RK_SCALAR = 2'd0;
	localparam logic [1:0] RK_HEADER = 2'd1;
	localparam logic [1:0] RK_BODY   = 2'd2;
	localparam logic [1:0] RK_ERROR  = 2'd3;

	localparam logic [2:0] VC_NULL   = 3'd0;
	localparam logic [2:0] VC_BOOL   = 3'd1;
	localparam logic [2:0] VC_INT    = 3'd2;
	localparam logic [2:0] VC_UINT   = 3'd3;
	localparam logic [2:0] VC_DOUBLE = 3'd4;
	localparam logic [2:0] VC_STRING = 3'd5;
	localparam logic [2:0] VC_JSON   = 3'd6;
	localparam logic [2:0] VC_BINARY = 3'd7;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;

	localparam logic [3:0] K_BOOL     = 4'd0;
	localparam logic [3:0] K_SHORT    = 4'd1;
	localparam logic [3:0] K_USHORT   = 4'd2;
	localparam logic [3:0] K_INT      = 4'd3;
	localparam logic [3:0] K_UINT     = 4'd4;
	localparam logic [3:0] K_LONG     = 4'd5;
	localparam logic [3:0] K_ULONG    = 4'd6;
	localparam logic [3:0] K_FLOAT    = 4'd7;
	localparam logic [3:0] K_DOUBLE   = 4'd8;
	localparam logic [3:0] K_STRING   = 4'd9;
	localparam logic [3:0] K_DATETIME = 4'd10;
	localparam logic [3:0] K_JSON     = 4'd11;
	localparam logic [3:0] K_BYTE     = 4'd12;
	localparam logic [3:0] K_UBYTE    = 4'd13;
	localparam logic [3:0] K_BINARY   = 4'd14;
	localparam logic [3:0] K_NONE     = 4'd15;

	typedef enum logic [2:0] {
		FMT_RAW    = 3'd0,
		FMT_BOOL   = 3'd1,
		FMT_SEXT16 = 3'd2,
		FMT_SEXT32 = 3'd3,
		FMT_F32    = 3'd4
	} fmt_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] blob_byte;
		logic       end_of_blob;
		logic [7:0] schema_column;
		logic [3:0] schema_kind;
		logic       schema_present;
	} item_t;

	typedef struct packed {
		logic       present;
		logic [3:0] kind;
	} entry_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [15:0] column_number;
		logic [2:0]  value_class;
		logic [63:0] value_bits;
		logic [1:0]  error_code;
		logic        last_of_record;
	} result_t;

	typedef struct packed {
		logic    vld;
		fmt_t    fmt;
		result_t res;
	} slot_t;

	function automatic logic [3:0] kind_size(input logic [3:0] k);
		logic [3:0] s;
		case (k)
			K_BOOL, K_BYTE, K_UBYTE:     s = 4'd1;
			K_SHORT, K_USHORT:           s = 4'd2;
			K_INT, K_UINT, K_FLOAT:      s = 4'd4;
			K_LONG, K_ULONG, K_DOUBLE:   s = 4'd8;
			default:                     s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] kind_class(input logic [3:0] k);
		logic [2:0] c;
		case (k)
			K_BOOL:                                   c = VC_BOOL;
			K_SHORT, K_INT, K_LONG:                   c = VC_INT;
			K_USHORT, K_UINT, K_ULONG, K_BYTE,
			K_UBYTE:                                  c = VC_UINT;
			K_FLOAT, K_DOUBLE:                        c = VC_DOUBLE;
			K_STRING, K_DATETIME:                     c = VC_STRING;
			K_JSON:                                   c = VC_JSON;
			K_BINARY:                                 c = VC_BINARY;
			default:                                  c = VC_NULL;
		endcase
		return c;
	endfunction

	function automatic fmt_t kind_fmt(input logic [3:0] k);
		fmt_t f;
		case (k)
			K_BOOL:  f = FMT_BOOL;
			K_SHORT: f = FMT_SEXT16;
			K_INT:   f = FMT_SEXT32;
			K_FLOAT: f = FMT_F32;
			default: f = FMT_RAW;
		endcase
		return f;
	endfunction

	function automatic result_t mk_res(input logic [1:0] rk, input logic [15:0] col,
		input logic [2:0] vc, input logic [63:0] bits, input logic [1:0] err,
		input logic last);
		result_t r;
		r.record_kind    = rk;
		r.column_number  = col;
		r.value_class    = vc;
		r.value_bits     = bits;
		r.error_code     = err;
		r.last_of_record = last;
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/tabp_table.sv
// ----------------------------------------------------------------------------
// tabp_table
// Schema table: kind memory with per-entry present bits, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tabp_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [7:0]        wr_addr,
	input  wire logic              wr_present,
	input  wire logic [3:0]        wr_kind,
	input  wire logic              rd_en,
	input  wire logic [7:0]        rd_addr,
	output tabp_pkg::entry_t       rd_entry
);

	logic [3:0]                     kind_mem [tabp_pkg::COL_SLOTS];
	logic [tabp_pkg::COL_SLOTS-1:0] present_q;
	logic [3:0]                     kind_q;
	logic                           rd_present_q;
	logic                           wr_in_range;
	logic                           rd_in_range;

	assign wr_in_range = {1'b0, wr_addr} < 9'(tabp_pkg::COL_SLOTS);
	assign rd_in_range = {1'b0, rd_addr} < 9'(tabp_pkg::COL_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q    <= '0;
			rd_present_q <= 1'b0;
		end else begin
			if (wr_en && wr_in_range) begin
				present_q[wr_addr[tabp_pkg::COL_AW-1:0]] <= wr_present;
			end
			if (rd_en) begin
				rd_present_q <= rd_in_range && present_q[rd_addr[tabp_pkg::COL_AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			kind_mem[wr_addr[tabp_pkg::COL_AW-1:0]] <= wr_kind;
		end
		if (rd_en) begin
			kind_q <= kind_mem[rd_addr[tabp_pkg::COL_AW-1:0]];
		end
	end

	assign rd_entry.present = rd_present_q;
	assign rd_entry.kind    = kind_q;

endmodule

`default_nettype wire

### hw/rtl/tabp_parse.sv
// ----------------------------------------------------------------------------
// tabp_parse
// Record parser state and per-item decode into up to two result slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tabp_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  tabp_pkg::item_t        item,
	input  tabp_pkg::entry_t       rd_entry,
	output tabp_pkg::slot_t        slot0,
	output tabp_pkg::slot_t        slot1
);

	typedef enum logic [4:0] {
		PH_COL_LO = 5'b00001,
		PH_COL_HI = 5'b00010,
		PH_FIXED  = 5'b00100,
		PH_LEN    = 5'b01000,
		PH_BODY   = 5'b10000
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [3:0]       pos_q, pos_n;
	logic [15:0]      col_q, col_n;
	logic [3:0]       kind_q, kind_n;
	logic [63:0]      acc_q, acc_n;
	logic [31:0]      rem_q, rem_n;
	logic             skip_q, skip_n;
	tabp_pkg::entry_t ent_q, ent_n;
	tabp_pkg::entry_t look;
	logic [7:0]       b;
	logic             eob;
	logic [63:0]      acc_add;
	logic [2:0]       vc;

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		col_n   = col_q;
		kind_n  = kind_q;
		acc_n   = acc_q;
		rem_n   = rem_q;
		skip_n  = skip_q;
		ent_n   = ent_q;
		slot0   = '0;
		slot1   = '0;
		look    = '0;
		b       = item.blob_byte;
		eob     = item.end_of_blob;
		acc_add = acc_q | ({56'd0, b} << {pos_q[2:0], 3'b000});
		vc      = tabp_pkg::kind_class(kind_q);

		if (item.opcode == tabp_pkg::OP_SCHEMA) begin
			if (item.schema_column == col_q[7:0]) begin
				ent_n.present = item.schema_present;
				ent_n.kind    = item.schema_kind;
			end
		end else if (skip_q) begin
			if (eob) begin
				skip_n  = 1'b0;
				phase_n = PH_COL_LO;
				pos_n   = '0;
			end
		end else begin
			case (phase_q)
				PH_COL_LO: begin
					col_n = {8'd0, b};
					ent_n = rd_entry;
					if (eob) begin
						slot0.vld = 1'b1;
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_n,
							tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
					end else begin
						phase_n = PH_COL_HI;
					end
				end
				PH_COL_HI: begin
					col_n   = {b, col_q[7:0]};
					phase_n = PH_COL_LO;
					if ({1'b0, col_n} < 17'(tabp_pkg::COL_SLOTS)) begin
						look = ent_q;
					end
					slot0.vld = 1'b1;
					if (!look.present) begin
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_n,
							tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_UNKNOWN, 1'b1);
						skip_n = !eob;
					end else begin
						kind_n = look.kind;
						pos_n  = '0;
						acc_n  = '0;
						if (look.kind == tabp_pkg::K_NONE) begin
							slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_SCALAR, col_n,
								tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_NONE, 1'b1);
						end else if (eob) begin
							slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_n,
								tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
						end else begin
							slot0.vld = 1'b0;
							phase_n   = (tabp_pkg::kind_size(look.kind) != 4'd0) ?
								PH_FIXED : PH_LEN;
						end
					end
				end
				PH_FIXED: begin
					acc_n = acc_add;
					pos_n = pos_q + 4'd1;
					if (pos_n >= tabp_pkg::kind_size(kind_q)) begin
						slot0.vld = 1'b1;
						slot0.fmt = tabp_pkg::kind_fmt(kind_q);
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_SCALAR, col_q, vc,
							acc_n, tabp_pkg::ERR_NONE, 1'b1);
						phase_n = PH_COL_LO;
					end else if (eob) begin
						slot0.vld = 1'b1;
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_q,
							tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
					end
				end
				PH_LEN: begin
					acc_n = acc_add;
					pos_n = pos_q + 4'd1;
					slot0.vld = 1'b0;
					if (pos_n >= 4'd4) begin
						slot0.vld = 1'b1;
						if (acc_n[31:0] == 32'd0) begin
							slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_HEADER, col_q, vc,
								'0, tabp_pkg::ERR_NONE, 1'b1);
							phase_n = PH_COL_LO;
						end else begin
							slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_HEADER, col_q, vc,
								{32'd0, acc_n[31:0]}, tabp_pkg::ERR_NONE, 1'b0);
							rem_n   = acc_n[31:0];
							phase_n = PH_BODY;
							if (eob) begin
								slot1.vld = 1'b1;
								slot1.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_q,
									tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
							end
						end
					end else if (eob) begin
						slot0.vld = 1'b1;
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_q,
							tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
					end
				end
				PH_BODY: begin
					rem_n     = rem_q - 32'd1;
					slot0.vld = 1'b1;
					if (rem_n == 32'd0) begin
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_BODY, col_q, vc,
							{56'd0, b}, tabp_pkg::ERR_NONE, 1'b1);
						phase_n = PH_COL_LO;
					end else begin
						slot0.res = tabp_pkg::mk_res(tabp_pkg::RK_BODY, col_q, vc,
							{56'd0, b}, tabp_pkg::ERR_NONE, 1'b0);
						if (eob) begin
							slot1.vld = 1'b1;
							slot1.res = tabp_pkg::mk_res(tabp_pkg::RK_ERROR, col_q,
								tabp_pkg::VC_NULL, '0, tabp_pkg::ERR_TRUNCATED, 1'b1);
						end
					end
				end
				default: begin
					phase_n = PH_COL_LO;
				end
			endcase
			if (eob) begin
				phase_n = PH_COL_LO;
				pos_n   = '0;
				skip_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COL_LO;
			pos_q   <= '0;
			col_q   <= '0;
			kind_q  <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			skip_q  <= 1'b0;
			ent_q   <= '0;
		end else if (go) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			col_q   <= col_n;
			kind_q  <= kind_n;
			acc_q   <= acc_n;
			rem_q   <= rem_n;
			skip_q  <= skip_n;
			ent_q   <= ent_n;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tabp_fmt.sv
// ----------------------------------------------------------------------------
// tabp_fmt
// Result stage: holds up to two results and widens scalar bits on the way out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tabp_fmt (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  tabp_pkg::slot_t        slot0,
	input  tabp_pkg::slot_t        slot1,
	input  wire logic              q_room,
	output logic                   free,
	output logic                   push0,
	output logic                   push1,
	output tabp_pkg::result_t      res0,
	output tabp_pkg::result_t      res1
);

	logic              vld0_s2;
	logic              vld1_s2;
	tabp_pkg::fmt_t    fmt_s2;
	tabp_pkg::result_t res0_s2;
	tabp_pkg::result_t res1_s2;
	logic              move;
	logic [63:0]       v;

	function automatic logic [63:0] widen_f32(input logic [31:0] f);
		logic [7:0]  e;
		logic [22:0] m;
		logic [4:0]  p;
		logic [22:0] sh;
		logic [63:0] r;
		e  = f[30:23];
		m  = f[22:0];
		p  = '0;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) begin
				p = 5'(i);
			end
		end
		sh = m << (5'd23 - p);
		if (e == 8'hFF) begin
			r = {f[31], 11'h7FF, m, 29'd0};
		end else if (e != 8'd0) begin
			r = {f[31], {3'd0, e} + 11'd896, m, 29'd0};
		end else if (m == 23'd0) begin
			r = {f[31], 63'd0};
		end else begin
			r = {f[31], {6'd0, p} + 11'd874, sh, 29'd0};
		end
		return r;
	endfunction

	assign move  = vld0_s2 && q_room;
	assign free  = !vld0_s2 || q_room;
	assign push0 = move;
	assign push1 = move && vld1_s2;

	always_comb begin
		case (fmt_s2)
			tabp_pkg::FMT_BOOL:   v = {63'd0, res0_s2.value_bits != 64'd0};
			tabp_pkg::FMT_SEXT16: v = {{48{res0_s2.value_bits[15]}}, res0_s2.value_bits[15:0]};
			tabp_pkg::FMT_SEXT32: v = {{32{res0_s2.value_bits[31]}}, res0_s2.value_bits[31:0]};
			tabp_pkg::FMT_F32:    v = widen_f32(res0_s2.value_bits[31:0]);
			default:              v = res0_s2.value_bits;
		endcase
		res0            = res0_s2;
		res0.value_bits = v;
		res1            = res1_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld0_s2 <= 1'b0;
			vld1_s2 <= 1'b0;
		end else if (load) begin
			vld0_s2 <= slot0.vld;
			vld1_s2 <= slot1.vld;
		end else if (move) begin
			vld0_s2 <= 1'b0;
			vld1_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fmt_s2  <= slot0.fmt;
			res0_s2 <= slot0.res;
			res1_s2 <= slot1.res;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/tabp_outq.sv
// ----------------------------------------------------------------------------
// tabp_outq
// Result queue: takes up to two results per cycle, gives at most one per cycle when popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tabp_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push0,
	input  wire logic              push1,
	input  tabp_pkg::result_t      d0,
	input  tabp_pkg::result_t      d1,
	input  wire logic              pop,
	output logic                   vld,
	output logic                   room,
	output tabp_pkg::result_t      head
);

	tabp_pkg::result_t      buf_q [tabp_pkg::QDEPTH];
	logic [tabp_pkg::QAW-1:0] wp_q;
	logic [tabp_pkg::QAW-1:0] rp_q;
	logic [tabp_pkg::QAW:0]   cnt_q;
	logic [tabp_pkg::QAW:0]   cnt_left;
	logic                     do_pop;

	assign vld      = cnt_q != '0;
	assign do_pop   = pop && vld;
	assign cnt_left = cnt_q - {{tabp_pkg::QAW{1'b0}}, do_pop};
	assign room     = cnt_left <= (tabp_pkg::QAW + 1)'(tabp_pkg::QDEPTH - 2);
	assign head     = buf_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + {{(tabp_pkg::QAW-1){1'b0}}, push0} +
				{{(tabp_pkg::QAW-1){1'b0}}, push1};
			rp_q  <= rp_q + {{(tabp_pkg::QAW-1){1'b0}}, do_pop};
			cnt_q <= cnt_left + {{tabp_pkg::QAW{1'b0}}, push0} +
				{{tabp_pkg::QAW{1'b0}}, push1};
		end
	end

	always_ff @(posedge clk) begin
		if (push0) begin
			buf_q[wp_q] <= d0;
		end
		if (push1) begin
			buf_q[wp_q + {{(tabp_pkg::QAW-1){1'b0}}, 1'b1}] <= d1;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/typed_attribute_blob_parser.sv
// ----------------------------------------------------------------------------
// typed_attribute_blob_parser
// Byte-serial parser of typed attribute blobs against a writable schema table.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | opcode, blob_byte, end_of_blob,
//           |           |                    | schema_column/kind/present
//   out     | output    | out_valid/out_stall| record_kind, column_number,
//           |           |                    | value_class, value_bits,
//           |           |                    | error_code, last_of_record
//
// One request per cycle while in_stall is low; results pass through the input
// register, result register and queue, and leave one per cycle at most while out_stall is low.
// A request that makes two results pushes both into the queue; they leave one after the other.
// Reset clears the schema table at once through its present bits.
// Stalls on the output back up through the queue and result stage to in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module typed_attribute_blob_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [7:0]  blob_byte,
	input  wire logic        end_of_blob,
	input  wire logic [7:0]  schema_column,
	input  wire logic [3:0]  schema_kind,
	input  wire logic        schema_present,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       record_kind,
	output logic [15:0]      column_number,
	output logic [2:0]       value_class,
	output logic [63:0]      value_bits,
	output logic [1:0]       error_code,
	output logic             last_of_record
);

	tabp_pkg::item_t   item_s1;
	logic              vld_s1;
	logic              accept;
	logic              go;
	tabp_pkg::entry_t  rd_entry;
	tabp_pkg::slot_t   slot0;
	tabp_pkg::slot_t   slot1;
	logic              s2_free;
	logic              q_room;
	logic              push0;
	logic              push1;
	tabp_pkg::result_t res0;
	tabp_pkg::result_t res1;
	tabp_pkg::result_t head;

	assign go       = vld_s1 && s2_free;
	assign in_stall = vld_s1 && !s2_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.opcode         <= opcode;
			item_s1.blob_byte      <= blob_byte;
			item_s1.end_of_blob    <= end_of_blob;
			item_s1.schema_column  <= schema_column;
			item_s1.schema_kind    <= schema_kind;
			item_s1.schema_present <= schema_present;
		end
	end

	tabp_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (accept && (opcode == tabp_pkg::OP_SCHEMA)),
		.wr_addr    (schema_column),
		.wr_present (schema_present),
		.wr_kind    (schema_kind),
		.rd_en      (accept && (opcode == tabp_pkg::OP_BYTE)),
		.rd_addr    (blob_byte),
		.rd_entry   (rd_entry)
	);

	tabp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.item     (item_s1),
		.rd_entry (rd_entry),
		.slot0    (slot0),
		.slot1    (slot1)
	);

	tabp_fmt u_fmt (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (go),
		.slot0  (slot0),
		.slot1  (slot1),
		.q_room (q_room),
		.free   (s2_free),
		.push0  (push0),
		.push1  (push1),
		.res0   (res0),
		.res1   (res1)
	);

	tabp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.d0     (res0),
		.d1     (res1),
		.pop    (!out_stall),
		.vld    (out_valid),
		.room   (q_room),
		.head   (head)
	);

	assign record_kind    = head.record_kind;
	assign column_number  = head.column_number;
	assign value_class    = head.value_class;
	assign value_bits     = head.value_bits;
	assign error_code     = head.error_code;
	assign last_of_record = head.last_of_record;

endmodule

`default_nettype wire
